// ===== rtl/tar_ustar_stream_deframer_top_assert.svh =====
// Assertion macros used by the tar deframer front module.
`ifndef TAR_USTAR_STREAM_DEFRAMER_TOP_ASSERT_SVH
`define TAR_USTAR_STREAM_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TUSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TUSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TUSD_ASSERT(label, clk, rst, prop, msg)
`define TUSD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/tusd_pkg.sv =====
// Shared types and constants of the tar deframer.
package tusd_pkg;

   localparam int unsigned RESULT_LENGTH_BITS = 36;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_BITS = 2;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [7:0]                    payload_byte;
      logic [7:0]                    entry_type;
      logic [RESULT_LENGTH_BITS-1:0] entry_length;
      logic                          name_is_empty;
      logic                          last_of_file;
   } result_type;

endpackage

// ===== rtl/tusd_front.sv =====
// Header parser and data sequencer: classifies each archive byte and produces results.
`include "tar_ustar_stream_deframer_top_assert.svh"

module tusd_front #(
   parameter int unsigned LENGTH_BITS = 36
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic [7:0]          in_byte,
   output logic                push,
   output tusd_pkg::result_type push_item
);

   localparam logic [8:0] BLOCK_LAST = 9'd511;
   localparam logic [8:0] SUM_FIRST  = 9'd148;
   localparam logic [8:0] SUM_LAST   = 9'd155;
   localparam logic [8:0] LEN_FIRST  = 9'd124;
   localparam logic [8:0] LEN_LAST   = 9'd135;
   localparam logic [8:0] TYPE_OFF   = 9'd156;
   localparam logic [8:0] NAME_OFF   = 9'd0;
   localparam logic [8:0] PREFIX_OFF = 9'd345;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_HALT   = 2'd2
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [8:0]             offset_ff, offset_in;
   logic [16:0]            sum_ff, sum_in;
   logic                   all_zero_ff, all_zero_in;
   logic                   prior_zero_ff, prior_zero_in;
   logic [23:0]            sum_val_ff, sum_val_in;
   logic [1:0]             sum_st_ff, sum_st_in;
   logic [LENGTH_BITS-1:0] len_val_ff, len_val_in;
   logic [1:0]             len_st_ff, len_st_in;
   logic [7:0]             type_ff, type_in;
   logic [1:0]             np_empty_ff, np_empty_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic                   forwarded_ff, forwarded_in;

   logic                   hdr_all_zero;
   logic [16:0]            hdr_sum;
   logic [23:0]            hdr_sum_val;
   logic [1:0]             hdr_sum_st;
   logic [LENGTH_BITS-1:0] hdr_len_val;
   logic [1:0]             hdr_len_st;
   logic [7:0]             hdr_type;
   logic [1:0]             hdr_np;
   logic [2:0]             sum_ctl;
   logic [2:0]             len_ctl;
   logic                   in_sum_field;
   logic                   in_len_field;
   logic                   hdr_empty;
   logic [LENGTH_BITS-1:0] rem_dec;

   // Returns the take-digit flag above the next started/stopped state.
   function automatic logic [2:0] octal_ctl(input logic [1:0] st, input logic [7:0] c);
      logic [2:0] r;
      r = {1'b0, st};
      if (!st[1]) begin
         if (c == CHAR_NUL) begin
            r = {1'b0, 1'b1, st[0]};
         end else if (c == CHAR_SPACE) begin
            r = {1'b0, st[0], st[0]};
         end else if (c inside {[CHAR_ZERO:CHAR_SEVEN]}) begin
            r = {1'b1, 1'b0, 1'b1};
         end else begin
            r = {1'b0, 1'b1, st[0]};
         end
      end
      return r;
   endfunction

   always_comb begin
      in_sum_field = (offset_ff >= SUM_FIRST) && (offset_ff <= SUM_LAST);
      in_len_field = (offset_ff >= LEN_FIRST) && (offset_ff <= LEN_LAST);
      sum_ctl      = octal_ctl(sum_st_ff, in_byte);
      len_ctl      = octal_ctl(len_st_ff, in_byte);
      hdr_all_zero = all_zero_ff && (in_byte == CHAR_NUL);
      hdr_sum      = in_sum_field ? 17'(sum_ff + 17'd32) : 17'(sum_ff + {9'd0, in_byte});
      hdr_sum_val  = sum_val_ff;
      hdr_sum_st   = sum_st_ff;
      if (in_sum_field) begin
         hdr_sum_st = sum_ctl[1:0];
         if (sum_ctl[2]) begin
            hdr_sum_val = {sum_val_ff[20:0], 3'b000} + {21'd0, in_byte[2:0]};
         end
      end
      hdr_len_val = len_val_ff;
      hdr_len_st  = len_st_ff;
      if (in_len_field) begin
         hdr_len_st = len_ctl[1:0];
         if (len_ctl[2]) begin
            hdr_len_val = {len_val_ff[LENGTH_BITS-4:0], 3'b000}
                        + LENGTH_BITS'(in_byte[2:0]);
         end
      end
      hdr_type = (offset_ff == TYPE_OFF) ? in_byte : type_ff;
      hdr_np   = np_empty_ff;
      if (offset_ff == NAME_OFF && in_byte == CHAR_NUL) begin
         hdr_np[0] = 1'b1;
      end
      if (offset_ff == PREFIX_OFF && in_byte == CHAR_NUL) begin
         hdr_np[1] = 1'b1;
      end
      hdr_empty = (hdr_np == 2'b11);
      rem_dec   = remaining_ff - LENGTH_BITS'(1);
   end

   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      sum_in        = sum_ff;
      all_zero_in   = all_zero_ff;
      prior_zero_in = prior_zero_ff;
      sum_val_in    = sum_val_ff;
      sum_st_in     = sum_st_ff;
      len_val_in    = len_val_ff;
      len_st_in     = len_st_ff;
      type_in       = type_ff;
      np_empty_in   = np_empty_ff;
      remaining_in  = remaining_ff;
      forwarded_in  = forwarded_ff;
      push          = 1'b0;
      push_item     = '0;
      if (in_accept) begin
         case (phase_ff)
            PH_DATA: begin
               offset_in = offset_ff + 9'd1;
               if (remaining_ff != '0) begin
                  remaining_in = rem_dec;
                  if (forwarded_ff) begin
                     push                   = 1'b1;
                     push_item.kind         = tusd_pkg::KIND_DATA;
                     push_item.payload_byte = in_byte;
                     push_item.last_of_file = (rem_dec == '0);
                  end
               end
               if (offset_ff == BLOCK_LAST && remaining_in == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               offset_in   = offset_ff + 9'd1;
               sum_in      = hdr_sum;
               all_zero_in = hdr_all_zero;
               sum_val_in  = hdr_sum_val;
               sum_st_in   = hdr_sum_st;
               len_val_in  = hdr_len_val;
               len_st_in   = hdr_len_st;
               type_in     = hdr_type;
               np_empty_in = hdr_np;
               if (offset_ff == BLOCK_LAST) begin
                  if (hdr_all_zero) begin
                     if (prior_zero_ff) begin
                        phase_in       = PH_HALT;
                        push           = 1'b1;
                        push_item.kind = tusd_pkg::KIND_END;
                     end else begin
                        prior_zero_in = 1'b1;
                     end
                  end else if (prior_zero_ff || hdr_sum_val != {7'd0, hdr_sum}) begin
                     phase_in       = PH_HALT;
                     push           = 1'b1;
                     push_item.kind = tusd_pkg::KIND_ERROR;
                  end else begin
                     push                    = 1'b1;
                     push_item.kind          = tusd_pkg::KIND_HEADER;
                     push_item.entry_type    = hdr_type;
                     push_item.entry_length  =
                        tusd_pkg::RESULT_LENGTH_BITS'(hdr_len_val);
                     push_item.name_is_empty = hdr_empty;
                     remaining_in            = hdr_len_val;
                     forwarded_in            = (hdr_type == CHAR_ZERO || hdr_type == CHAR_NUL)
                                             && !hdr_empty;
                     phase_in                = (hdr_len_val != '0) ? PH_DATA : PH_HEADER;
                  end
               end
            end
            default: begin
            end
         endcase
         if (phase_in == PH_HEADER && offset_in == 9'd0) begin
            sum_in      = '0;
            all_zero_in = 1'b1;
            sum_val_in  = '0;
            sum_st_in   = '0;
            len_val_in  = '0;
            len_st_in   = '0;
            type_in     = '0;
            np_empty_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         offset_ff     <= '0;
         sum_ff        <= '0;
         all_zero_ff   <= 1'b1;
         prior_zero_ff <= 1'b0;
         sum_val_ff    <= '0;
         sum_st_ff     <= '0;
         len_val_ff    <= '0;
         len_st_ff     <= '0;
         type_ff       <= '0;
         np_empty_ff   <= '0;
         remaining_ff  <= '0;
         forwarded_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         sum_ff        <= sum_in;
         all_zero_ff   <= all_zero_in;
         prior_zero_ff <= prior_zero_in;
         sum_val_ff    <= sum_val_in;
         sum_st_ff     <= sum_st_in;
         len_val_ff    <= len_val_in;
         len_st_ff     <= len_st_in;
         type_ff       <= type_in;
         np_empty_ff   <= np_empty_in;
         remaining_ff  <= remaining_in;
         forwarded_ff  <= forwarded_in;
      end
   end

   `TUSD_ASSERT(halt_is_final, clock, reset, (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT), "halted state left before reset")
   `TUSD_ASSERT(block_results_at_end, clock, reset, (push && push_item.kind != tusd_pkg::KIND_DATA) |-> (phase_ff == PH_HEADER && offset_ff == BLOCK_LAST), "header result away from block end")
   `TUSD_ASSERT(data_only_forwarded, clock, reset, (push && push_item.kind == tusd_pkg::KIND_DATA) |-> (phase_ff == PH_DATA && forwarded_ff && remaining_ff != '0), "data result outside a forwarded file")

endmodule

// ===== rtl/tusd_queue.sv =====
// Result queue between the parser and the output channel.
module tusd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tusd_pkg::result_type push_item,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tusd_pkg::result_type out_item
);

   localparam int unsigned PW = tusd_pkg::QUEUE_PTR_BITS;

   tusd_pkg::result_type mem_ff [tusd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PW:0]          count_ff, count_in;
   logic                 pop;

   assign full      = (count_ff == (PW+1)'(tusd_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/tar_ustar_stream_deframer_top.sv =====
// Top level of the tar archive stream deframer.
//
//   Channel  Ports        Direction  Carries
//   req      req_t*       in         one archive byte per transfer
//   rsp      rsp_t*       out        one header, data, end or error result per transfer
//
// One archive byte is taken every cycle while the result queue is not full; the parser
// finishes each byte in the cycle of its transfer and writes any result into a
// four-entry queue. A result is offered on rsp once the results ahead of it are taken.
// req_tready drops only while the result queue is full, so rsp stalls reach req after
// four waiting results. Reset is synchronous and clears the parser and queue at once;
// after an end of archive or an error result bytes are taken and dropped until reset.
module tar_ustar_stream_deframer_top #(
   parameter int unsigned LENGTH_BITS = 36
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // archive_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // payload_byte[7:0], entry_type[15:8],
                                    // entry_length[51:16], name_is_empty[52], zero[55:53]
   output logic [1:0]  rsp_tuser,   // result_kind[1:0]
   output logic        rsp_tlast    // last_of_file
);

   logic                 queue_full;
   logic                 in_accept;
   logic                 push;
   tusd_pkg::result_type push_item;
   tusd_pkg::result_type out_item;

   assign req_tready = !queue_full;
   assign in_accept  = req_tvalid && req_tready;

   tusd_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .push      (push),
      .push_item (push_item)
   );

   tusd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {3'b000, out_item.name_is_empty, out_item.entry_length,
                       out_item.entry_type, out_item.payload_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last_of_file;

endmodule
